// ----- rtl/mstc_pkg.sv -----
// Shared constants and types for the spanning-tree centre block.
// No dependencies.
`timescale 1ns / 1ps
package mstc_pkg;
    localparam int MAX_NODES  = 32;
    localparam int MAX_EDGES  = 512;
    localparam int NODE_W     = 5;
    localparam int WEIGHT_W   = 16;
    localparam int EIDX_W     = 9;
    localparam int ECNT_W     = 10;
    localparam int EDGE_W     = 2 * NODE_W + WEIGHT_W;
    localparam int DIST_W     = 6;
    localparam logic [5:0] NODE_COUNT_RESET = 6'd32;
endpackage

// ----- rtl/mstc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module mstc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- rtl/max_spanning_tree_center.sv -----
// Top level of the maximum spanning forest centre block.
// Depends on mstc_pkg and mstc_ram.
// Sequence: edges are stored while idle; after the last edge the sequencer runs E
//   selection passes that each read every stored edge (E = stored edges), a
//   relabel over all nodes per merging edge, a neighbour scan per queue entry in
//   each leaf walk, then the minimum scan and the emit scan over the nodes.
// Throughput: one edge per cycle while loading; busy is high during compute.
// Reset: synchronous active low; clears counters, labels, degrees, adjacency.
`timescale 1ns / 1ps
module max_spanning_tree_center (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [4:0] i_src_node,
    input  logic [4:0] i_dst_node,
    input  logic [15:0] i_weight,
    input  logic       i_has_model,
    input  logic       i_last_edge,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [5:0] i_cfg_data,
    output logic       o_valid,
    output logic [4:0] o_center_node,
    output logic [4:0] o_tree_radius,
    output logic       o_last_center
);
    localparam int NW = mstc_pkg::NODE_W;
    localparam int EW = mstc_pkg::EIDX_W;
    localparam int CW = mstc_pkg::ECNT_W;
    localparam int WW = mstc_pkg::WEIGHT_W;
    localparam int DW = mstc_pkg::DIST_W;
    localparam int MN = mstc_pkg::MAX_NODES;

    // Sequencer states
    localparam logic [3:0] S_IDLE = 4'd0, S_INIT = 4'd1, S_SCAN = 4'd2,
        S_SCANW = 4'd3, S_PICK = 4'd4, S_PICKW = 4'd5, S_UNION = 4'd6,
        S_RELAB = 4'd7, S_LEAF = 4'd8, S_BFS = 4'd9, S_MERGE = 4'd10,
        S_MIN = 4'd11, S_EMIT = 4'd12;

    logic [3:0] r_state;
    logic [5:0] r_node_count;
    logic [CW-1:0] r_edge_count;
    logic [NW-1:0] r_label [MN];
    logic [NW-1:0] r_degree [MN];
    logic [MN-1:0] r_adj [MN];
    logic [DW-1:0] r_wd [MN];
    logic [DW-1:0] r_ld [MN];
    logic [NW-1:0] r_queue [MN];
    // last edge taken by the sort: next pick is the best key strictly below it
    logic r_prev_ok;
    logic [WW-1:0] r_prev_w;
    logic [CW-1:0] r_prev_idx;
    logic [CW-1:0] r_idx, r_best_idx, r_pass;
    logic [WW-1:0] r_best_w;
    logic r_best_ok;
    logic [NW:0] r_k, r_head, r_tail, r_leaf;
    logic [MN-1:0] r_seen;
    logic [NW-1:0] r_a, r_b, r_la, r_lb;
    logic [DW-1:0] r_min;
    logic [NW:0] r_n;

    logic store_we;
    logic [EW-1:0] ram_raddr;
    logic [mstc_pkg::EDGE_W-1:0] ram_rdata;

    assign busy = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign store_we = start && !busy && i_has_model &&
        (r_edge_count < CW'(mstc_pkg::MAX_EDGES));
    assign ram_raddr = r_idx[EW-1:0];

    mstc_ram #(.WIDTH(mstc_pkg::EDGE_W), .DEPTH(mstc_pkg::MAX_EDGES)) u_edges (
        .i_clk(i_clk), .i_we(store_we), .i_waddr(r_edge_count[EW-1:0]),
        .i_wdata({i_src_node, i_dst_node, i_weight}),
        .i_raddr(ram_raddr), .o_rdata(ram_rdata));

    logic [NW-1:0] rd_a, rd_b;
    logic [WW-1:0] rd_w;
    assign {rd_a, rd_b, rd_w} = ram_rdata;

    logic [NW-1:0] kk, uu;
    assign kk = r_k[NW-1:0];
    assign uu = r_queue[r_head[NW-1:0]];
    logic [5:0] nclamp;
    assign nclamp = (r_node_count == 6'd0) ? 6'd1 :
        ((r_node_count > 6'd32) ? 6'd32 : r_node_count);

    // Sort order: heavier first, earlier arrival first on equal weight.
    logic scan_cand, scan_take;
    assign scan_cand = !r_prev_ok || (rd_w < r_prev_w) ||
        (rd_w == r_prev_w && r_idx > r_prev_idx);
    assign scan_take = scan_cand && (!r_best_ok || rd_w > r_best_w);

    // Emit scan: current node is a centre, and whether a later one follows
    logic emit_hit, later_hit;
    assign emit_hit = (r_state == S_EMIT) && (r_k < r_n) && (r_ld[kk] == r_min);
    always_comb begin
        later_hit = 1'b0;
        for (int j = 0; j < MN; j++)
            if ((NW+1)'(j) > r_k && (NW+1)'(j) < r_n && r_ld[j] == r_min)
                later_hit = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
            r_state <= S_IDLE;
            r_node_count <= mstc_pkg::NODE_COUNT_RESET;
            r_edge_count <= '0;
            for (int i = 0; i < MN; i++) begin
                r_label[i] <= NW'(i); r_degree[i] <= '0; r_adj[i] <= '0;
                r_wd[i] <= '0; r_ld[i] <= '0;
            end
        end else begin
            o_valid <= emit_hit;
            if (emit_hit) begin
                o_center_node <= kk;
                o_tree_radius <= (r_min > DW'(31)) ? 5'd31 : r_min[4:0];
                o_last_center <= !later_hit;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid) r_node_count <= i_cfg_data;
                    if (store_we) r_edge_count <= r_edge_count + 1'b1;
                    if (start && i_last_edge) begin
                        r_n <= nclamp;
                        r_state <= S_INIT;
                    end
                end
                S_INIT: begin
                    for (int i = 0; i < MN; i++) begin
                        r_label[i] <= NW'(i); r_degree[i] <= '0; r_adj[i] <= '0;
                        r_ld[i] <= '0;
                    end
                    r_prev_ok <= 1'b0; r_pass <= '0;
                    r_idx <= '0; r_best_ok <= 1'b0; r_best_w <= '0;
                    r_state <= (r_edge_count == '0) ? S_LEAF : S_SCAN;
                    r_leaf <= '0;
                end
                // Select the heaviest edge not yet taken; earliest wins ties.
                S_SCAN: r_state <= S_SCANW; // read latency
                S_SCANW: begin
                    if (scan_take) begin
                        r_best_ok <= 1'b1; r_best_w <= rd_w; r_best_idx <= r_idx;
                    end
                    if (r_idx + 1'b1 == r_edge_count) begin
                        r_idx <= scan_take ? r_idx : r_best_idx;
                        r_state <= S_PICK;
                    end else begin
                        r_idx <= r_idx + 1'b1; r_state <= S_SCAN;
                    end
                end
                S_PICK: r_state <= S_PICKW;
                S_PICKW: begin
                    r_prev_ok <= 1'b1; r_prev_w <= rd_w; r_prev_idx <= r_idx;
                    r_a <= rd_a; r_b <= rd_b;
                    r_la <= r_label[rd_a]; r_lb <= r_label[rd_b];
                    if ({1'b0, rd_a} >= r_n || {1'b0, rd_b} >= r_n
                        || r_label[rd_a] == r_label[rd_b])
                        r_state <= S_RELAB;
                    else begin
                        r_state <= S_UNION; r_k <= '0;
                    end
                end
                S_UNION: begin
                    if (r_label[kk] == r_lb) r_label[kk] <= r_la;
                    if (r_k == (NW+1)'(MN-1)) begin
                        r_adj[r_a][r_b] <= 1'b1; r_adj[r_b][r_a] <= 1'b1;
                        r_degree[r_a] <= r_degree[r_a] + 1'b1;
                        r_degree[r_b] <= r_degree[r_b] + 1'b1;
                        r_state <= S_RELAB;
                    end
                    r_k <= r_k + 1'b1;
                end
                S_RELAB: begin // next sort pass
                    r_idx <= '0; r_best_ok <= 1'b0;
                    if (r_pass + 1'b1 == r_edge_count) begin
                        r_state <= S_LEAF; r_leaf <= '0;
                    end else begin
                        r_pass <= r_pass + 1'b1; r_state <= S_SCAN;
                    end
                end
                S_LEAF: begin
                    if (r_leaf >= r_n) begin
                        r_min <= r_ld[0]; r_k <= (NW+1)'(1); r_state <= S_MIN;
                    end else if (r_degree[r_leaf[NW-1:0]] == NW'(1)) begin
                        for (int i = 0; i < MN; i++) r_wd[i] <= '0;
                        r_queue[0] <= r_leaf[NW-1:0];
                        r_seen <= MN'(1) << r_leaf[NW-1:0];
                        r_head <= '0; r_tail <= (NW+1)'(1); r_k <= '0;
                        r_state <= S_BFS;
                    end else r_leaf <= r_leaf + 1'b1;
                end
                // One neighbour candidate per cycle for the queue head.
                S_BFS: begin
                    if (r_head == r_tail) r_state <= S_MERGE;
                    else begin
                        if (r_k < r_n && r_adj[uu][kk] && !r_seen[kk]
                            && r_tail < (NW+1)'(MN)) begin
                            r_seen[kk] <= 1'b1;
                            r_wd[kk] <= r_wd[uu] + 1'b1;
                            r_queue[r_tail[NW-1:0]] <= kk;
                            r_tail <= r_tail + 1'b1;
                        end
                        if (r_k == (NW+1)'(MN-1)) begin
                            r_k <= '0; r_head <= r_head + 1'b1;
                        end else r_k <= r_k + 1'b1;
                    end
                end
                S_MERGE: begin
                    for (int i = 0; i < MN; i++)
                        if ((NW+1)'(i) < r_n && r_wd[i] > r_ld[i]) r_ld[i] <= r_wd[i];
                    r_leaf <= r_leaf + 1'b1; r_state <= S_LEAF;
                end
                S_MIN: begin
                    if (r_k >= r_n) begin
                        r_k <= '0; r_state <= S_EMIT;
                    end else begin
                        if (r_ld[kk] < r_min) r_min <= r_ld[kk];
                        r_k <= r_k + 1'b1;
                    end
                end
                // One node per cycle; a matching node is a centre transaction.
                S_EMIT: begin
                    if (r_k >= r_n) begin
                        r_state <= S_IDLE; r_edge_count <= '0;
                    end else r_k <= r_k + 1'b1;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_out_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |=> !o_valid || $past(r_state) == S_EMIT)
        else $error("result outside emit");
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> !busy) else $error("cfg while busy");
`endif
endmodule

// ----- bench/tb.sv -----
// Self-checking bench for the maximum spanning forest centre block.
// Depends on mstc_pkg and the max_spanning_tree_center RTL.
`timescale 1ns / 1ps
module tb;
    localparam int PER = 12;

    typedef enum logic [1:0] {K_EDGE, K_CFG, K_PAUSE} t_job_kind;

    typedef struct {
        t_job_kind kind;
        logic [4:0] src;
        logic [4:0] dst;
        logic [15:0] wgt;
        logic hm;
        logic last;
        logic [5:0] cfg;
        int gap_pct;        // chance in a hundred that the sender holds the edge back at a decision
    } t_job;

    typedef struct {
        logic [4:0] node;
        logic [4:0] radius;
        logic last;
    } t_centre;

    logic i_clk = 0, i_rst_n = 0;
    logic start = 0, busy;
    logic [4:0] i_src_node = 0, i_dst_node = 0;
    logic [15:0] i_weight = 0;
    logic i_has_model = 0, i_last_edge = 0;
    logic i_cfg_valid = 0, o_cfg_ready;
    logic [5:0] i_cfg_data = 0;
    logic o_valid, o_last_center;
    logic [4:0] o_center_node, o_tree_radius;

    max_spanning_tree_center uut (.*);

    t_job jobs[$];
    t_centre centres_due[$];
    int errors = 0;
    bit all_sent = 0;
    bit edge_taken = 0, cfg_taken = 0;
    int quiet = 0;

    // Bench copy of the block state
    logic [4:0] m_a[mstc_pkg::MAX_EDGES], m_b[mstc_pkg::MAX_EDGES];
    logic [15:0] m_w[mstc_pkg::MAX_EDGES];
    int m_cnt = 0;
    logic [5:0] m_nodes = mstc_pkg::NODE_COUNT_RESET;

    initial forever #(PER / 2) i_clk = ~i_clk;

    task automatic report(string what, int got, int want);
        $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Sort, Kruskal, leaf walks and centre selection for the stored batch.
    task automatic predict_centres();
        int n, i, j, k, cur, u, hd, tl, minv, rad, nres;
        int ord[mstc_pkg::MAX_EDGES];
        int lab[mstc_pkg::MAX_NODES], deg[mstc_pkg::MAX_NODES];
        int far[mstc_pkg::MAX_NODES], walk_dist[mstc_pkg::MAX_NODES];
        int wq[mstc_pkg::MAX_NODES];
        logic [mstc_pkg::MAX_NODES-1:0] adj[mstc_pkg::MAX_NODES];
        logic [mstc_pkg::MAX_NODES-1:0] seen;
        int la, lb, a, b;
        t_centre c;
        n = m_nodes;
        if (n == 0) n = 1;
        if (n > mstc_pkg::MAX_NODES) n = mstc_pkg::MAX_NODES;
        for (i = 0; i < mstc_pkg::MAX_NODES; i++) begin
            lab[i] = i; deg[i] = 0; far[i] = 0; adj[i] = '0;
        end
        // stable descending insertion sort
        for (i = 0; i < m_cnt; i++) begin
            cur = i; j = i;
            while (j > 0 && m_w[ord[j-1]] < m_w[cur]) begin
                ord[j] = ord[j-1]; j--;
            end
            ord[j] = cur;
        end
        for (i = 0; i < m_cnt; i++) begin
            a = m_a[ord[i]]; b = m_b[ord[i]];
            if (a >= n || b >= n) continue;
            la = lab[a]; lb = lab[b];
            if (la == lb) continue;
            for (k = 0; k < n; k++) if (lab[k] == lb) lab[k] = la;
            adj[a][b] = 1'b1; adj[b][a] = 1'b1;
            deg[a]++; deg[b]++;
        end
        for (i = 0; i < n; i++) begin
            if (deg[i] != 1) continue;
            for (k = 0; k < mstc_pkg::MAX_NODES; k++) walk_dist[k] = 0;
            seen = '0; seen[i] = 1'b1;
            hd = 0; tl = 0; wq[tl++] = i;
            while (hd < tl) begin
                u = wq[hd++];
                for (k = 0; k < n; k++)
                    if (adj[u][k] && !seen[k] && tl < mstc_pkg::MAX_NODES) begin
                        seen[k] = 1'b1;
                        walk_dist[k] = walk_dist[u] + 1;
                        wq[tl++] = k;
                    end
            end
            for (k = 0; k < n; k++) if (walk_dist[k] > far[k]) far[k] = walk_dist[k];
        end
        minv = far[0];
        for (i = 1; i < n; i++) if (far[i] < minv) minv = far[i];
        rad = (minv > 31) ? 31 : minv;
        nres = 0;
        for (i = 0; i < n && nres < 32; i++)
            if (far[i] == minv) begin
                c.node = i[4:0]; c.radius = rad[4:0]; c.last = 1'b0;
                centres_due = {centres_due, c};
                nres++;
            end
        if (nres > 0) centres_due[$].last = 1'b1;
        m_cnt = 0;
    endtask

    // Monitor: samples every transaction at the rising edge
    always @(posedge i_clk) begin
        t_centre want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                m_nodes = i_cfg_data;
                cfg_taken = 1;
            end
            if (start && !busy) begin
                edge_taken = 1;
                if (i_has_model && m_cnt < mstc_pkg::MAX_EDGES) begin
                    m_a[m_cnt] = i_src_node; m_b[m_cnt] = i_dst_node;
                    m_w[m_cnt] = i_weight; m_cnt++;
                end
                if (i_last_edge) predict_centres();
            end
            if (o_valid) begin
                if (centres_due.size() == 0) begin
                    report("unexpected centre", o_center_node, -1);
                end else begin
                    want = centres_due.pop_front();
                    if (o_center_node !== want.node)
                        report("center_node", o_center_node, want.node);
                    if (o_tree_radius !== want.radius)
                        report("tree_radius", o_tree_radius, want.radius);
                    if (o_last_center !== want.last)
                        report("last_center", o_last_center, want.last);
                end
            end
        end
    end

    // Driver: one decision per falling edge, one assignment per signal
    always @(negedge i_clk) begin
        logic nxt_start, nxt_cfg;
        t_job j;
        if (i_rst_n) begin
            nxt_start = start;
            nxt_cfg = i_cfg_valid;
            if (start && edge_taken) nxt_start = 0;
            if (i_cfg_valid && cfg_taken) nxt_cfg = 0;
            edge_taken = 0;
            cfg_taken = 0;
            if (centres_due.size() == 0 && !busy) quiet++; else quiet = 0;
            if (!nxt_start && !nxt_cfg) begin
                if (jobs.size() == 0) begin
                    all_sent = 1;
                end else begin
                    j = jobs[0];
                    case (j.kind)
                        K_EDGE: begin
                            if ($urandom_range(99) >= j.gap_pct) begin
                                void'(jobs.pop_front());
                                i_src_node <= j.src; i_dst_node <= j.dst;
                                i_weight <= j.wgt; i_has_model <= j.hm;
                                i_last_edge <= j.last;
                                nxt_start = 1;
                            end
                        end
                        K_CFG: begin
                            // idle and drained for a while before a write
                            if (quiet > 40) begin
                                void'(jobs.pop_front());
                                i_cfg_data <= j.cfg;
                                nxt_cfg = 1;
                            end
                        end
                        default: begin
                            if (quiet > 40) void'(jobs.pop_front());
                        end
                    endcase
                end
            end
            start <= nxt_start;
            i_cfg_valid <= nxt_cfg;
        end
    end

    task automatic add_edge(int s, int d, int w, int hm, int last, int gap);
        t_job j;
        j.kind = K_EDGE; j.src = 5'(s); j.dst = 5'(d); j.wgt = 16'(w);
        j.hm = 1'(hm); j.last = 1'(last); j.cfg = '0; j.gap_pct = gap;
        jobs = {jobs, j};
    endtask

    task automatic add_ctl(t_job_kind k, int v);
        t_job j;
        j.kind = k; j.src = '0; j.dst = '0; j.wgt = '0; j.hm = 1'b0; j.last = 1'b0;
        j.cfg = 6'(v); j.gap_pct = 0;
        jobs = {jobs, j};
    endtask

    // Random batch: mostly usable edges among the live nodes, some noise
    task automatic add_batch(int len, int nodes, int gap);
        int i, s, d, hm, r;
        for (i = 0; i < len; i++) begin
            r = $urandom_range(99);
            s = (r < 85) ? $urandom_range(nodes - 1) : $urandom_range(31);
            d = (r < 85) ? $urandom_range(nodes - 1) : $urandom_range(31);
            hm = ($urandom_range(9) != 0);
            add_edge(s, d, ($urandom_range(3) == 0) ? $urandom_range(3) : $urandom,
                     hm, i == len - 1, gap);
        end
    endtask

    initial begin
        int i, nodes, gaps[3], v;
        gaps[0] = 0; gaps[1] = 87; gaps[2] = 16;

        // directed: reset node count of 32
        add_edge(3, 4, 0, 0, 1, 0);             // nothing usable: all centres
        add_edge(31, 0, 65535, 1, 0, 0);        // extreme nodes and weight
        add_edge(0, 1, 0, 1, 0, 0);
        add_edge(1, 1, 100, 1, 0, 0);           // self loop
        add_edge(0, 31, 5, 1, 0, 0);            // same node pair as the first edge, reversed
        add_edge(1, 2, 7, 1, 1, 0);
        add_ctl(K_CFG, 4);
        add_edge(0, 1, 9, 1, 0, 0);             // equal weights: arrival order decides
        add_edge(1, 2, 9, 1, 0, 0);
        add_edge(0, 2, 9, 1, 0, 0);
        add_edge(2, 7, 50, 1, 0, 0);            // endpoint beyond node count
        add_edge(2, 3, 1, 1, 1, 0);
        add_ctl(K_CFG, 1);
        add_edge(0, 0, 3, 1, 1, 0);
        add_ctl(K_CFG, 0);                      // treated as one node
        add_edge(0, 1, 3, 1, 1, 0);
        add_ctl(K_CFG, 63);                     // clamps to full size
        for (i = 0; i < 5; i++) add_edge(i, i + 1, 10, 1, i == 4, 0);
        add_ctl(K_PAUSE, 0);

        // random batches across idle phases and node counts
        nodes = 32;
        for (i = 0; i < 48; i++) begin
            if (i % 4 == 0) begin
                v = $urandom_range(5);
                case (v)
                    0: nodes = 1;
                    1: nodes = 32;
                    2: nodes = $urandom_range(2, 8);
                    default: nodes = $urandom_range(2, 32);
                endcase
                add_ctl(K_CFG, nodes);
            end
            if (i % 10 == 9) add_ctl(K_PAUSE, 0);
            add_batch($urandom_range(1, 11), nodes, gaps[(i / 4) % 3]);
        end

        add_ctl(K_CFG, 32);
        add_batch(8, 32, 87);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        wait (all_sent);
        wait (centres_due.size() == 0);
        repeat (300) @(posedge i_clk);
        if (errors == 0 && centres_due.size() == 0)
            $display("max_spanning_tree_center verification clean");
        else
            $display("max_spanning_tree_center verification failed");
        $finish;
    end

    // Watchdog
    initial begin
        #(PER * 3000000);
        $display("max_spanning_tree_center verification failed");
        $finish;
    end
endmodule
